@@ rtl/life_automaton_grid_top_assert.svh @@
// Assertion macros for the life automaton grid checker.
`ifndef LIFE_AUTOMATON_GRID_TOP_ASSERT_SVH
`define LIFE_AUTOMATON_GRID_TOP_ASSERT_SVH

// Checked while out of reset.
`define LAG_ASSERT(name, clk_e, rstn_e, prop, msg) \
	name: assert property (@(posedge clk_e) disable iff (!rstn_e) prop) else $error(msg);

// Checked at every edge, reset included.
`define LAG_ASSERT_ALWAYS(name, clk_e, prop, msg) \
	name: assert property (@(posedge clk_e) prop) else $error(msg);

`endif

@@ rtl/lag_pkg.sv @@
// Shared types and constants for the life automaton grid.
`default_nettype none
package lag_pkg;

	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 8;
	localparam int KIND_W   = 2;
	localparam int ROW_W    = 5;
	localparam int COL_W    = 5;
	localparam int ROW_LSB  = 0;
	localparam int COL_LSB  = ROW_LSB + ROW_W;
	localparam int WV_LSB   = COL_LSB + COL_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE   = 2'd0,
		KIND_READ    = 2'd1,
		KIND_ADVANCE = 2'd2,
		KIND_CLEAR   = 2'd3
	} lag_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CELL_RD,
		ST_CELL_DATA,
		ST_CLEAR,
		ST_ADV_PRIME,
		ST_ADV_LOAD,
		ST_ADV_RUN,
		ST_DONE
	} lag_state_t;

	typedef struct packed {
		logic capture;
		logic cell_rd;
		logic cell_wr;
		logic cell_get;
		logic clr;
		logic adv_start;
		logic adv_load;
		logic adv_step;
		logic load_out;
	} lag_cmd_t;

	typedef struct packed {
		lag_kind_t kind;
		logic      last_row;
		logic      out_free;
	} lag_sts_t;

endpackage
`default_nettype wire

@@ rtl/lag_ctrl.sv @@
// Sequencer for cell access, clear and generation sweep.
`default_nettype none
module lag_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic [1:0]        s_tuser,
	output logic                   s_tready,
	input  wire lag_pkg::lag_sts_t sts,
	output lag_pkg::lag_cmd_t      cmd
);
	import lag_pkg::*;

	lag_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					unique case (lag_kind_t'(s_tuser))
						KIND_WRITE, KIND_READ: state_d = ST_CELL_RD;
						KIND_ADVANCE:          state_d = ST_ADV_PRIME;
						KIND_CLEAR:            state_d = ST_CLEAR;
						default:               state_d = ST_CLEAR;
					endcase
				end
			end
			ST_CELL_RD: begin
				cmd.cell_rd = 1'b1;
				state_d     = ST_CELL_DATA;
			end
			ST_CELL_DATA: begin
				// row word is back: merge for a write, pick the bit for a read
				if (sts.kind == KIND_WRITE) begin
					cmd.cell_wr = 1'b1;
				end else begin
					cmd.cell_get = 1'b1;
				end
				state_d = ST_DONE;
			end
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				state_d = ST_DONE;
			end
			ST_ADV_PRIME: begin
				cmd.adv_start = 1'b1;
				state_d       = ST_ADV_LOAD;
			end
			ST_ADV_LOAD: begin
				cmd.adv_load = 1'b1;
				state_d      = ST_ADV_RUN;
			end
			ST_ADV_RUN: begin
				cmd.adv_step = 1'b1;
				if (sts.last_row) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/lag_dp.sv @@
// Grid memory, row window, B3/S23 row update and result register.
`default_nettype none
module lag_dp #(
	parameter int ROWS    = 32,
	parameter int COLUMNS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [lag_pkg::S_DATA_W-1:0] s_tdata,
	input  wire logic [1:0]                   s_tuser,
	input  wire logic                         m_tready,
	output logic                              m_tvalid,
	output logic [lag_pkg::M_DATA_W-1:0]      m_tdata,
	output logic [1:0]                        m_tuser,
	input  wire lag_pkg::lag_cmd_t            cmd,
	output lag_pkg::lag_sts_t                 sts
);
	import lag_pkg::*;

	localparam int RAW = $clog2(ROWS);
	localparam int CAW = $clog2(COLUMNS);

	// captured item
	lag_kind_t        kind_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             wv_q;

	// grid storage, one word per row; a row without its valid bit reads as dead
	logic [COLUMNS-1:0] mem [ROWS];
	logic [ROWS-1:0]    row_valid_q;
	logic [COLUMNS-1:0] rd_data_q;
	logic               rd_valid_q;
	logic [COLUMNS-1:0] rd_eff;

	logic               rd_en, wr_en;
	logic [RAW-1:0]     rd_addr, wr_addr;
	logic [COLUMNS-1:0] wr_data;

	// sweep state
	logic [RAW-1:0]     wr_row_q;
	logic [RAW:0]       ahead;
	logic               ahead_ok;
	logic [COLUMNS-1:0] win_above_q, win_cur_q;
	logic [COLUMNS-1:0] below, new_row;

	// cell access
	logic               in_grid;
	logic [RAW-1:0]     row_idx;
	logic [CAW-1:0]     col_idx;
	logic [COLUMNS-1:0] bit_mask, merged;
	logic               res_q;

	// result register
	logic            out_valid_q;
	logic            out_rv_q;
	lag_kind_t       out_kind_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= lag_kind_t'(s_tuser);
			row_q  <= s_tdata[ROW_LSB +: ROW_W];
			col_q  <= s_tdata[COL_LSB +: COL_W];
			wv_q   <= s_tdata[WV_LSB];
		end
	end

	assign in_grid = (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS);
	assign row_idx = RAW'(row_q);
	assign col_idx = CAW'(col_q);
	assign rd_eff  = rd_valid_q ? rd_data_q : '0;

	assign bit_mask = COLUMNS'(1) << col_idx;
	assign merged   = wv_q ? (rd_eff | bit_mask) : (rd_eff & ~bit_mask);

	assign ahead    = {1'b0, wr_row_q} + (RAW+1)'(2);
	assign ahead_ok = ahead < (RAW+1)'(ROWS);

	assign rd_en = cmd.cell_rd | cmd.adv_start | cmd.adv_load | (cmd.adv_step & ahead_ok);
	always_comb begin
		if (cmd.cell_rd) begin
			rd_addr = row_idx;
		end else if (cmd.adv_start) begin
			rd_addr = '0;
		end else if (cmd.adv_load) begin
			rd_addr = RAW'(1);
		end else begin
			rd_addr = ahead[RAW-1:0];
		end
	end

	assign wr_en   = (cmd.cell_wr & in_grid) | cmd.adv_step;
	assign wr_addr = cmd.cell_wr ? row_idx : wr_row_q;
	assign wr_data = cmd.cell_wr ? merged : new_row;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (cmd.clr) begin
				row_valid_q <= '0;
			end else if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= row_valid_q[rd_addr];
			end
		end
	end

	// old rows above and at the sweep position; the row below comes from memory
	assign sts.last_row = (wr_row_q == RAW'(ROWS-1));
	assign below        = sts.last_row ? '0 : rd_eff;

	always_ff @(posedge clk) begin
		if (cmd.adv_start) begin
			wr_row_q    <= '0;
			win_above_q <= '0;
		end else if (cmd.adv_load) begin
			win_cur_q <= rd_eff;
		end else if (cmd.adv_step) begin
			wr_row_q    <= wr_row_q + RAW'(1);
			win_above_q <= win_cur_q;
			win_cur_q   <= below;
		end
	end

	// dead border on both sides so every column sees three cells per row
	logic [COLUMNS+1:0] ab_p, cu_p, be_p;
	assign ab_p = {1'b0, win_above_q, 1'b0};
	assign cu_p = {1'b0, win_cur_q, 1'b0};
	assign be_p = {1'b0, below, 1'b0};

	for (genvar c = 0; c < COLUMNS; c++) begin : g_col
		logic [3:0] cnt;
		assign cnt = 4'(ab_p[c]) + 4'(ab_p[c+1]) + 4'(ab_p[c+2])
			+ 4'(cu_p[c]) + 4'(cu_p[c+2])
			+ 4'(be_p[c]) + 4'(be_p[c+1]) + 4'(be_p[c+2]);
		assign new_row[c] = (cnt == 4'd3) | (win_cur_q[c] & (cnt == 4'd2));
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_q <= 1'b0;
		end else if (cmd.cell_get) begin
			res_q <= in_grid & rd_eff[col_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_rv_q   <= (kind_q == KIND_READ) ? res_q : 1'b0;
			out_kind_q <= kind_q;
		end
	end

	assign sts.kind     = kind_q;
	assign sts.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(M_DATA_W-1)'(0), out_rv_q};
	assign m_tuser  = out_kind_q;

endmodule
`default_nettype wire

@@ rtl/life_automaton_grid_top.sv @@
// Top level of the life automaton grid (B3/S23 on a bounded grid).
// Holds a ROWS x COLUMNS grid of cells, all dead after reset. Each input
// transaction carries a kind in s_tuser: write one cell, read one cell,
// advance one generation, or clear the grid; each gives exactly one output
// transaction echoing the kind, with the cell value for a read. Cells past
// the edge count as dead, and indexes past the grid make a write do nothing
// and a read return dead. One item is worked at a time. A cell write or read
// passes a row read, then a merge or bit pick, to the output register, and a
// clear one clear step; a generation reads rows 0 and 1, then the sweep updates
// one row per cycle from a two-row window of old rows plus the row below read
// from the grid memory, whose single read and write port set that pace. The
// next item is accepted in the cycle after a result is loaded; a waiting result
// holds the block only when the next result is ready to be loaded.
`default_nettype none
module life_automaton_grid_top #(
	parameter int ROWS    = 32,
	parameter int COLUMNS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [lag_pkg::S_DATA_W-1:0] s_tdata,  // row[4:0], column[9:5], write_value[10]
	input  wire logic [1:0]                   s_tuser,  // kind[1:0]
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [lag_pkg::M_DATA_W-1:0]      m_tdata,  // read_value[0]
	output logic [1:0]                        m_tuser   // done_kind[1:0]
);
	import lag_pkg::*;

	lag_cmd_t cmd;
	lag_sts_t sts;

	lag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lag_dp #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
`default_nettype wire

@@ rtl/lag_checker.sv @@
// Port-level checks for the life automaton grid, bound to the top level.
`default_nettype none
`include "life_automaton_grid_top_assert.svh"
module lag_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         s_tvalid,
	input wire logic                         s_tready,
	input wire logic                         m_tvalid,
	input wire logic                         m_tready,
	input wire logic [lag_pkg::M_DATA_W-1:0] m_tdata,
	input wire logic [1:0]                   m_tuser
);
	import lag_pkg::*;

	`LAG_ASSERT_ALWAYS(a_no_out_in_reset, clk, !arst_n |-> !m_tvalid, "output valid in reset")
	`LAG_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output changed")
	`LAG_ASSERT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "accepted twice in a row")
	`LAG_ASSERT(a_rv_only_read, clk, arst_n, m_tvalid && (m_tuser != KIND_READ) |-> (m_tdata == '0), "read value set on non-read")

endmodule

bind life_automaton_grid_top lag_checker u_lag_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

@@ verif/life_automaton_grid_top_test.sv @@
// Self-checking stream testbench for the life automaton grid top level.
`default_nettype none
module life_automaton_grid_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lag_pkg::*;

	localparam int TB_ROWS     = 32;
	localparam int TB_COLS     = 32;
	localparam int DIRECTED_N  = 24;
	localparam int RANDOM_N    = 900;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = TB_ROWS + 16;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		lag_kind_t kind;
		bit [4:0]  row;
		bit [4:0]  column;
		bit        write_value;
		bit        fixed;        // read_value typed into the table
		bit        fixed_value;
	} grid_op_t;

	typedef struct {
		bit        read_value;
		lag_kind_t done_kind;
	} cell_result_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [1:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [1:0]          m_tuser;

	bit [TB_COLS-1:0]   life_grid [TB_ROWS];
	cell_result_t       expected_results [$];
	int                 mismatches;
	int                 results_seen;
	int                 items_sent;
	int                 cycle_count;
	bit                 send_quiet;
	bit                 recv_quiet;

	grid_op_t directed_ops [DIRECTED_N] = '{
		'{KIND_READ,    5'd0,  5'd0,  1'b0, 1'b1, 1'b0},
		'{KIND_READ,    5'd31, 5'd31, 1'b0, 1'b1, 1'b0},
		'{KIND_ADVANCE, 5'd0,  5'd0,  1'b0, 1'b1, 1'b0},  // empty grid stays empty
		'{KIND_READ,    5'd15, 5'd15, 1'b0, 1'b1, 1'b0},
		'{KIND_WRITE,   5'd0,  5'd0,  1'b1, 1'b1, 1'b0},
		'{KIND_WRITE,   5'd31, 5'd31, 1'b1, 1'b1, 1'b0},
		'{KIND_READ,    5'd0,  5'd0,  1'b0, 1'b1, 1'b1},
		'{KIND_READ,    5'd31, 5'd31, 1'b0, 1'b1, 1'b1},
		'{KIND_WRITE,   5'd0,  5'd1,  1'b1, 1'b1, 1'b0},  // blinker on the top edge
		'{KIND_WRITE,   5'd0,  5'd2,  1'b1, 1'b1, 1'b0},
		'{KIND_ADVANCE, 5'd31, 5'd31, 1'b1, 1'b1, 1'b0},
		'{KIND_READ,    5'd0,  5'd1,  1'b0, 1'b0, 1'b0},
		'{KIND_READ,    5'd1,  5'd1,  1'b0, 1'b0, 1'b0},
		'{KIND_READ,    5'd0,  5'd0,  1'b0, 1'b0, 1'b0},
		'{KIND_READ,    5'd31, 5'd31, 1'b0, 1'b0, 1'b0},
		'{KIND_WRITE,   5'd31, 5'd30, 1'b1, 1'b1, 1'b0},  // L shape in the far corner
		'{KIND_WRITE,   5'd30, 5'd31, 1'b1, 1'b1, 1'b0},
		'{KIND_WRITE,   5'd30, 5'd30, 1'b1, 1'b1, 1'b0},
		'{KIND_ADVANCE, 5'd0,  5'd0,  1'b0, 1'b1, 1'b0},
		'{KIND_READ,    5'd31, 5'd31, 1'b0, 1'b0, 1'b0},
		'{KIND_CLEAR,   5'd31, 5'd31, 1'b1, 1'b1, 1'b0},
		'{KIND_READ,    5'd1,  5'd1,  1'b0, 1'b1, 1'b0},
		'{KIND_WRITE,   5'd31, 5'd0,  1'b0, 1'b1, 1'b0},
		'{KIND_READ,    5'd31, 5'd0,  1'b0, 1'b1, 1'b0}
	};

	life_automaton_grid_top #(
		.ROWS    (TB_ROWS),
		.COLUMNS (TB_COLS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// B3/S23, every cell from the old grid, nothing past the edge
	function automatic void step_generation();
		bit [TB_COLS-1:0] prior [TB_ROWS];
		int rr;
		int cc;
		int n;
		prior = life_grid;
		for (int r = 0; r < TB_ROWS; r++) begin
			for (int c = 0; c < TB_COLS; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						rr = r + dr;
						cc = c + dc;
						if ((dr != 0 || dc != 0) && rr >= 0 && rr < TB_ROWS &&
						    cc >= 0 && cc < TB_COLS)
							n += prior[rr][cc];
					end
				end
				if (prior[r][c])
					life_grid[r][c] = (n == 2 || n == 3);
				else
					life_grid[r][c] = (n == 3);
			end
		end
	endfunction

	function automatic cell_result_t apply_op(grid_op_t op);
		cell_result_t res;
		bit           in_grid;
		in_grid = (op.row < TB_ROWS) && (op.column < TB_COLS);
		res.read_value = 1'b0;
		res.done_kind  = op.kind;
		case (op.kind)
			KIND_WRITE: begin
				if (in_grid)
					life_grid[op.row][op.column] = op.write_value;
			end
			KIND_READ: begin
				if (in_grid)
					res.read_value = life_grid[op.row][op.column];
			end
			KIND_ADVANCE: step_generation();
			default: begin
				foreach (life_grid[r])
					life_grid[r] = '0;
			end
		endcase
		return res;
	endfunction

	// mostly none, some short, a few long
	function automatic int idle_cycles(bit quiet, int long_pct);
		int pick;
		pick = $urandom_range(0, 99);
		if (quiet || pick >= 30)
			return 0;
		if (pick >= long_pct)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic grid_op_t window_op(lag_kind_t kind, int base_r, int base_c, int w);
		grid_op_t op;
		op.kind        = kind;
		op.row         = 5'(base_r + $urandom_range(0, w - 1));
		op.column      = 5'(base_c + $urandom_range(0, w - 1));
		op.write_value = ($urandom_range(0, 99) < 45);
		op.fixed       = 1'b0;
		op.fixed_value = 1'b0;
		return op;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_op(input grid_op_t op);
		cell_result_t res;
		int           gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, op.write_value, op.column, op.row};
		s_tuser  <= op.kind;
		do @(posedge clk); while (!s_tready);
		res = apply_op(op);
		if (op.fixed)
			res.read_value = op.fixed_value;
		expected_results.push_back(res);
		items_sent++;
		if ($urandom_range(0, 59) == 0)
			send_quiet = !send_quiet;
		@(negedge clk);
		gap = idle_cycles(send_quiet, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// stimulus
	initial begin
		grid_op_t op;
		int       w;
		int       base_r;
		int       base_c;
		int       pick;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		foreach (life_grid[r])
			life_grid[r] = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_N; i++)
			send_op(directed_ops[i]);

		while (items_sent < DIRECTED_N + RANDOM_N) begin
			// seed a small patch, often against an edge, then let it evolve
			w = $urandom_range(3, 8);
			pick = $urandom_range(0, 2);
			base_r = (pick == 0) ? 0 : (pick == 1) ? TB_ROWS - w :
				$urandom_range(0, TB_ROWS - w);
			pick = $urandom_range(0, 2);
			base_c = (pick == 0) ? 0 : (pick == 1) ? TB_COLS - w :
				$urandom_range(0, TB_COLS - w);
			repeat ($urandom_range(8, 24))
				send_op(window_op(KIND_WRITE, base_r, base_c, w));
			repeat ($urandom_range(1, 4)) begin
				send_op(window_op(KIND_ADVANCE, base_r, base_c, w));
				repeat ($urandom_range(3, 10))
					send_op(window_op(KIND_READ, base_r, base_c, w));
			end
			if ($urandom_range(0, 99) < 20) begin
				// stray transactions anywhere in the grid
				repeat ($urandom_range(1, 6)) begin
					op = window_op(lag_kind_t'($urandom_range(0, 3)), 0, 0, TB_ROWS);
					if (op.kind == KIND_CLEAR && $urandom_range(0, 1))
						op.kind = KIND_READ;
					send_op(op);
				end
			end
			if ($urandom_range(0, 99) < 30)
				send_op(window_op(KIND_CLEAR, 0, 0, TB_ROWS));
		end
		s_tvalid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// receiver: random stalls plus two long hold-offs that back up the input
	initial begin
		int stall;
		bit held_early;
		bit held_late;
		m_tready   = 1'b0;
		held_early = 1'b0;
		held_late  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ((!held_early && results_seen >= 150) || (!held_late && results_seen >= 600)) begin
				if (held_early)
					held_late = 1'b1;
				held_early = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if ($urandom_range(0, 79) == 0)
					recv_quiet = !recv_quiet;
				stall = idle_cycles(recv_quiet, 2);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			m_tready <= 1'b1;
		end
	end

	// result check
	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("unexpected transaction: read_value %0b done_kind %0d",
					m_tdata[0], m_tuser);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[0] !== want.read_value) begin
					$error("read_value: expected %0b, actual %0b", want.read_value, m_tdata[0]);
					mismatches++;
				end
				if (m_tuser !== want.done_kind) begin
					$error("done_kind: expected %0d, actual %0d", want.done_kind, m_tuser);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/lag_pkg.sv
rtl/lag_ctrl.sv
rtl/lag_dp.sv
rtl/life_automaton_grid_top.sv
rtl/lag_checker.sv
verif/life_automaton_grid_top_test.sv
